/* rtl/scbb_pkg.sv */
// Shared types, constants and the seek helper for the sparse chunk byte buffer.
// Used by scbb_ctrl, scbb_dp and sparse_chunk_byte_buffer; depends on nothing.
`default_nettype none

package scbb_pkg;

   localparam int CHUNK_BYTES = 4096;
   localparam int CHUNK_COUNT = 16;
   localparam int CAPACITY    = CHUNK_BYTES * CHUNK_COUNT;

   localparam int ADDR_W  = $clog2(CAPACITY);
   localparam int PTR_W   = ADDR_W + 1;
   localparam int OFS_W   = $clog2(CHUNK_BYTES);
   localparam int FILL_W  = OFS_W + 1;
   localparam int CHUNK_W = (ADDR_W > OFS_W) ? ADDR_W - OFS_W : 1;
   localparam int DATA_W  = 8;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int ORG_W   = 2;

   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 48;

   localparam logic [PTR_W-1:0]  CAP_PTR    = PTR_W'(CAPACITY);
   localparam logic [FILL_W-1:0] FULL_CHUNK = FILL_W'(CHUNK_BYTES);

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 3'd0,
      OP_READ    = 3'd1,
      OP_SEEK_WR = 3'd2,
      OP_SEEK_RD = 3'd3,
      OP_QUERY   = 3'd4
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK         = 2'd0,
      ST_WRITE_DROP = 2'd1,
      ST_NO_DATA    = 2'd2
   } status_type;

   typedef enum logic [ORG_W-1:0] {
      ORG_START = 2'd0,
      ORG_REL   = 2'd1,
      ORG_END   = 2'd2
   } origin_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic walk_step;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic walk_last;
   } stat_type;

   // New pointer value for a seek; saturates at capacity and at zero.
   function automatic logic [PTR_W-1:0] seek_pos(input logic [PTR_W-1:0] cur,
                                                 input logic [PTR_W-1:0] off,
                                                 input logic [ORG_W-1:0] origin);
      logic [PTR_W:0] sum;
      logic [PTR_W-1:0] res;
      sum = {1'b0, cur} + {1'b0, off};
      case (origin)
         ORG_START: res = (off > CAP_PTR) ? CAP_PTR : off;
         ORG_REL:   res = (sum > {1'b0, CAP_PTR}) ? CAP_PTR : sum[PTR_W-1:0];
         ORG_END:   res = (off > CAP_PTR) ? '0 : CAP_PTR - off;
         default:   res = cur;
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

/* rtl/scbb_ctrl.sv */
// Controller state machine of the sparse chunk byte buffer.
// Depends on scbb_pkg; drives the handshakes and the commands of scbb_dp.
`default_nettype none

module scbb_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output scbb_pkg::cmd_type      cmd,
   input  wire scbb_pkg::stat_type stat
);

   scbb_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scbb_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scbb_pkg::S_IDLE: begin
            if (req_tvalid) state_in = scbb_pkg::S_EXEC;
         end
         scbb_pkg::S_EXEC: begin
            state_in = stat.is_query ? scbb_pkg::S_WALK : scbb_pkg::S_DONE;
         end
         scbb_pkg::S_WALK: begin
            if (stat.walk_last) state_in = scbb_pkg::S_DONE;
         end
         scbb_pkg::S_DONE: begin
            if (rsp_tready) state_in = scbb_pkg::S_IDLE;
         end
         default: state_in = scbb_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_tready    = 1'b0;
      rsp_tvalid    = 1'b0;
      cmd           = '0;
      case (state_ff)
         scbb_pkg::S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         scbb_pkg::S_EXEC: begin
            cmd.exec = 1'b1;
         end
         scbb_pkg::S_WALK: begin
            cmd.walk_step = 1'b1;
         end
         scbb_pkg::S_DONE: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

/* rtl/scbb_dp.sv */
// Datapath of the sparse chunk byte buffer: byte memory, chunk fill marks,
// pointers and result registers. Depends on scbb_pkg; commanded by scbb_ctrl.
`default_nettype none

module scbb_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire scbb_pkg::cmd_type            cmd,
   output scbb_pkg::stat_type                stat,
   input  wire logic [scbb_pkg::OP_W-1:0]    req_operation,
   input  wire logic [scbb_pkg::DATA_W-1:0]  req_write_data,
   input  wire logic [scbb_pkg::PTR_W-1:0]   req_seek_offset,
   input  wire logic [scbb_pkg::ORG_W-1:0]   req_seek_origin,
   output logic [scbb_pkg::STAT_W-1:0]       rsp_status,
   output logic [scbb_pkg::DATA_W-1:0]       rsp_read_data,
   output logic [scbb_pkg::PTR_W-1:0]        rsp_readable_length,
   output logic [scbb_pkg::PTR_W-1:0]        rsp_read_position
);

   logic [scbb_pkg::OP_W-1:0]    op_ff;
   logic [scbb_pkg::DATA_W-1:0]  wdata_ff;
   logic [scbb_pkg::PTR_W-1:0]   off_ff;
   logic [scbb_pkg::ORG_W-1:0]   origin_ff;
   logic [scbb_pkg::PTR_W-1:0]   rp_ff, rp_in;
   logic [scbb_pkg::PTR_W-1:0]   wp_ff, wp_in;
   logic [scbb_pkg::PTR_W-1:0]   scan_ff, scan_in;
   logic [scbb_pkg::PTR_W-1:0]   len_ff, len_in;
   logic [scbb_pkg::STAT_W-1:0]  status_ff, status_in;
   logic                         rd_ok_ff, rd_ok_in;
   logic [scbb_pkg::FILL_W-1:0]  fill_ff [scbb_pkg::CHUNK_COUNT];
   logic [scbb_pkg::FILL_W-1:0]  fill_in;
   logic                         fill_we;
   logic [scbb_pkg::DATA_W-1:0]  mem [scbb_pkg::CAPACITY];
   logic [scbb_pkg::DATA_W-1:0]  mem_q_ff;
   logic                         mem_we, mem_re;

   logic [scbb_pkg::CHUNK_W-1:0] chunk_idx;
   logic [scbb_pkg::FILL_W-1:0]  ro;
   logic [scbb_pkg::FILL_W-1:0]  fill_rd;
   logic [scbb_pkg::FILL_W-1:0]  delta;
   logic                         beyond;
   logic                         below_fill;
   logic                         stop_now;

   // One lookup of the fill marks, always at the chunk of the scan position.
   assign chunk_idx  = scan_ff[scbb_pkg::ADDR_W-1:scbb_pkg::OFS_W];
   assign ro         = {1'b0, scan_ff[scbb_pkg::OFS_W-1:0]};
   assign fill_rd    = fill_ff[chunk_idx];
   assign beyond     = (scan_ff >= scbb_pkg::CAP_PTR);
   assign below_fill = (ro < fill_rd);
   assign delta      = fill_rd - ro;
   assign stop_now   = beyond || !below_fill;

   assign stat.is_query  = (op_ff == scbb_pkg::OP_QUERY);
   assign stat.walk_last = stop_now || (fill_rd != scbb_pkg::FULL_CHUNK);

   always_comb begin
      rp_in     = rp_ff;
      wp_in     = wp_ff;
      scan_in   = scan_ff;
      len_in    = len_ff;
      status_in = status_ff;
      rd_ok_in  = rd_ok_ff;
      fill_in   = ro + scbb_pkg::FILL_W'(1);
      fill_we   = 1'b0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      if (cmd.capture) begin
         scan_in   = (req_operation == scbb_pkg::OP_WRITE) ? wp_ff : rp_ff;
         len_in    = '0;
         status_in = scbb_pkg::ST_OK;
         rd_ok_in  = 1'b0;
      end else if (cmd.exec) begin
         case (op_ff)
            scbb_pkg::OP_WRITE: begin
               if (beyond) begin
                  status_in = scbb_pkg::ST_WRITE_DROP;
               end else begin
                  mem_we  = 1'b1;
                  fill_we = (fill_rd < fill_in);
                  wp_in   = wp_ff + scbb_pkg::PTR_W'(1);
               end
            end
            scbb_pkg::OP_READ: begin
               if (!beyond && below_fill) begin
                  mem_re   = 1'b1;
                  rd_ok_in = 1'b1;
                  rp_in    = rp_ff + scbb_pkg::PTR_W'(1);
               end else begin
                  status_in = scbb_pkg::ST_NO_DATA;
               end
            end
            scbb_pkg::OP_SEEK_WR: wp_in = scbb_pkg::seek_pos(wp_ff, off_ff, origin_ff);
            scbb_pkg::OP_SEEK_RD: rp_in = scbb_pkg::seek_pos(rp_ff, off_ff, origin_ff);
            default: status_in = scbb_pkg::ST_OK;
         endcase
      end else if (cmd.walk_step) begin
         if (!stop_now) begin
            len_in  = len_ff + scbb_pkg::PTR_W'(delta);
            scan_in = scan_ff + scbb_pkg::PTR_W'(delta);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rp_ff <= '0;
         wp_ff <= '0;
         for (int i = 0; i < scbb_pkg::CHUNK_COUNT; i++) begin
            fill_ff[i] <= '0;
         end
      end else begin
         rp_ff <= rp_in;
         wp_ff <= wp_in;
         if (fill_we) fill_ff[chunk_idx] <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff     <= req_operation;
         wdata_ff  <= req_write_data;
         off_ff    <= req_seek_offset;
         origin_ff <= req_seek_origin;
      end
      scan_ff   <= scan_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
   end

   // Single-port byte memory with registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) mem[scan_ff[scbb_pkg::ADDR_W-1:0]] <= wdata_ff;
      if (mem_re) mem_q_ff <= mem[scan_ff[scbb_pkg::ADDR_W-1:0]];
   end

   assign rsp_status          = status_ff;
   assign rsp_read_data       = rd_ok_ff ? mem_q_ff : '0;
   assign rsp_readable_length = len_ff;
   assign rsp_read_position   = rp_ff;

   a_rp_range: assert property (@(posedge clock) disable iff (reset)
      rp_ff <= scbb_pkg::CAP_PTR)
      else $error("read pointer beyond capacity");

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= scbb_pkg::CAP_PTR)
      else $error("write pointer beyond capacity");

   a_walk_boundary: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step && !stat.walk_last) |=> (scan_ff[scbb_pkg::OFS_W-1:0] == '0))
      else $error("length walk continued off a chunk boundary");

   a_drop_only_beyond: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && op_ff == scbb_pkg::OP_WRITE && !beyond) |=> $past(wp_ff) + 1'b1 == wp_ff)
      else $error("accepted write did not advance the write pointer");

endmodule

`default_nettype wire

/* rtl/sparse_chunk_byte_buffer.sv */
// Top level of the sparse chunk byte buffer: stream ports, field packing and
// the controller/datapath pair. Depends on scbb_pkg, scbb_ctrl and scbb_dp.
//
// The block stores up to 64 KiB in sixteen 4 KiB chunks, each with a fill
// high-water mark (zero means the chunk is absent), plus separate read and
// write pointers. Each request on the req_ channel performs one operation:
// write a byte, read a byte, seek the writer, seek the reader, or query how
// many bytes are readable from the read pointer. Every request produces
// exactly one response on the rsp_ channel, in order.
//
// Timing: the block works on one request at a time. For write, read, seek and
// no-op codes, the accepted request passes through S_EXEC, and rsp_tvalid
// rises in S_DONE, where the response is handed off. A length query walks
// one chunk per cycle in S_WALK, between S_EXEC and S_DONE; when all sixteen
// chunks are full, the walk stops at capacity. The next request is taken in
// the cycle after the response is handed off. The per-cycle limit is the
// single port of the byte memory and the one fill-mark lookup of the walk.
//
// Reset clears both pointers and all fill marks, so every chunk is absent.
// Byte contents are not cleared. While the receiver holds rsp_tready low the
// response stays stable on rsp_tdata and no new request is accepted.
`default_nettype none

module sparse_chunk_byte_buffer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // operation[2:0], write_data[10:3], seek_offset[27:11], seek_origin[29:28]
   input  wire logic [scbb_pkg::REQ_TDATA_W-1:0]    req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // status[1:0], read_data[9:2], readable_length[26:10], read_position[43:27]
   output logic [scbb_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);

   scbb_pkg::cmd_type  cmd;
   scbb_pkg::stat_type stat;

   logic [scbb_pkg::STAT_W-1:0] rsp_status;
   logic [scbb_pkg::DATA_W-1:0] rsp_read_data;
   logic [scbb_pkg::PTR_W-1:0]  rsp_readable_length;
   logic [scbb_pkg::PTR_W-1:0]  rsp_read_position;

   // Controller: handshakes and sequencing of each request.
   scbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // Datapath: memory, fill marks, pointers; result registers hold the
   // response while the receiver stalls.
   scbb_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_tdata[2:0]),
      .req_write_data      (req_tdata[10:3]),
      .req_seek_offset     (req_tdata[27:11]),
      .req_seek_origin     (req_tdata[29:28]),
      .rsp_status          (rsp_status),
      .rsp_read_data       (rsp_read_data),
      .rsp_readable_length (rsp_readable_length),
      .rsp_read_position   (rsp_read_position)
   );

   assign rsp_tdata = {4'b0000, rsp_read_position, rsp_readable_length,
                       rsp_read_data, rsp_status};

endmodule

`default_nettype wire
